// ===== hw/rtl/rms_dbfs_level_meter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// RMS dBFS level meter assertion macros
// Shared concurrent assertion forms for the meter's checker.
// ----------------------------------------------------------------------------
`ifndef RMS_DBFS_LEVEL_METER_UNIT_MACROS_SVH
`define RMS_DBFS_LEVEL_METER_UNIT_MACROS_SVH

// condition holds at every edge outside reset
`define RDLM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define RDLM_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rdlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rdlm_pkg
// Types, constants and helper functions shared by the level meter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rdlm_pkg;

  localparam int WINDOW_SAMPLES_DEF = 512;
  localparam int FIFO_DEPTH         = 4;

  localparam logic signed [15:0] DB_FLOOR_Q8     = -16'sd30720;
  localparam logic [18:0]        TEN_LOG10_2_Q16 = 19'd197283;
  localparam logic [9:0]         LEVEL_MAX       = 10'd1000;

  localparam logic signed [15:0] FLOOR_RST = -16'sd14336;
  localparam logic signed [15:0] LOUD_RST  = -16'sd4608;

  // register indexes (word address)
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_FLOOR  = 2'd1;
  localparam logic [1:0] REG_LOUD   = 2'd2;

  typedef struct packed {
    logic enable;
    logic clear;
  } front_ctl_t;

  typedef struct packed {
    logic               clear_peak;
    logic signed [15:0] floor_db;
    logic signed [15:0] loud_db;
  } back_ctl_t;

  // queue entry: error flag, sample sum, square sum
  function automatic int entry_w(input int n);
    return 1 + 17 + 30 + 2 * $clog2(n + 1);
  endfunction

  // log2 in Q16 with truncated fraction, for elaboration-time constants
  function automatic longint log2_q16_const(input longint x);
    logic [63:0] xx;
    logic [63:0] y;
    longint      r;
    int          p;
    xx = x;
    p  = 63;
    while (p > 0 && xx[p] == 1'b0) p = p - 1;
    if (p >= 31) y = xx >> (p - 31);
    else y = xx << (31 - p);
    r = longint'(p) * 65536;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        r = r + (longint'(1) << i);
        y = y >> 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rms_dbfs_level_meter_unit.sv =====
// ----------------------------------------------------------------------------
// rms_dbfs_level_meter_unit
// Windowed RMS audio level meter with dBFS, 0..1000 level and peak output.
// ----------------------------------------------------------------------------
// The front end takes one sample beat per clock as long as its four-entry
// job queue has room. Each finished window then goes through the back
// end's serial units in turn: a shift-add multiply, a one-bit-per-cycle
// normalizer, a 16-step log2 squaring loop and, where the level needs
// one, a 10-step divider. A read-error beat skips them. One result at a
// time sits in the output register; the queue absorbs bursts of read
// errors.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_dbfs_level_meter_unit #(
  parameter int WINDOW_SAMPLES = rdlm_pkg::WINDOW_SAMPLES_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  // configuration
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [3:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // samples
  input  wire               push,
  output logic              full,
  input  wire signed [15:0] in_sample,
  input  wire               in_read_error,
  // results
  output logic              empty,
  input  wire               pop,
  output logic [9:0]        out_level,
  output logic [9:0]        out_peak,
  output logic signed [15:0] out_dbfs_q8
);
  import rdlm_pkg::*;

  localparam int EW = entry_w(WINDOW_SAMPLES);

  logic               en_r, en_nxt;
  logic signed [15:0] floor_r, floor_nxt, loud_r, loud_nxt;
  logic               wr;
  logic [1:0]         idx;
  logic               en_chg;
  front_ctl_t         fctl;
  back_ctl_t          bctl;
  logic               q_push, q_full, q_pop, q_empty;
  logic [EW-1:0]      q_wdata, q_rdata;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];
  assign en_chg = wr && (idx == REG_ENABLE) && (pwdata[0] != en_r);

  // register writes
  always_comb begin
    en_nxt    = en_r;
    floor_nxt = floor_r;
    loud_nxt  = loud_r;
    if (wr) begin
      unique case (idx)
        REG_ENABLE: en_nxt = pwdata[0];
        REG_FLOOR:  floor_nxt = pwdata[15:0];
        REG_LOUD:   loud_nxt = pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      floor_r <= FLOOR_RST;
      loud_r  <= LOUD_RST;
    end else begin
      en_r    <= en_nxt;
      floor_r <= floor_nxt;
      loud_r  <= loud_nxt;
    end
  end

  // register readback
  always_comb begin
    unique case (idx)
      REG_ENABLE: prdata = {31'b0, en_r};
      REG_FLOOR:  prdata = {16'b0, floor_r};
      REG_LOUD:   prdata = {16'b0, loud_r};
      default:    prdata = '0;
    endcase
  end

  assign fctl.enable     = en_r;
  assign fctl.clear      = en_chg;
  assign bctl.clear_peak = en_chg & pwdata[0];
  assign bctl.floor_db   = floor_r;
  assign bctl.loud_db    = loud_r;

  rdlm_front #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (fctl),
    .push          (push),
    .full          (full),
    .in_sample     (in_sample),
    .in_read_error (in_read_error),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  rdlm_fifo #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  rdlm_back #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (bctl),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_level   (out_level),
    .out_peak    (out_peak),
    .out_dbfs_q8 (out_dbfs_q8)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rdlm_front.sv =====
// ----------------------------------------------------------------------------
// rdlm_front
// Sample front end: accumulates sum and sum of squares per window and
// queues a job at each window end or read error.
// ----------------------------------------------------------------------------
`default_nettype none

module rdlm_front #(
  parameter int WINDOW_SAMPLES = rdlm_pkg::WINDOW_SAMPLES_DEF
) (
  input  wire                                           clk,
  input  wire                                           rst_n,
  input  rdlm_pkg::front_ctl_t                          ctl,
  input  wire                                           push,
  output logic                                          full,
  input  wire signed [15:0]                             in_sample,
  input  wire                                           in_read_error,
  input  wire                                           q_full,
  output logic                                          q_push,
  output logic [rdlm_pkg::entry_w(WINDOW_SAMPLES)-1:0]  q_data
);
  import rdlm_pkg::*;

  localparam int NB    = $clog2(WINDOW_SAMPLES + 1);
  localparam int SUM_W = 17 + NB;
  localparam int SQ_W  = 30 + NB;
  localparam int CNT_W = $clog2(WINDOW_SAMPLES);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW_SAMPLES - 1);

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic                    accept;
  logic signed [31:0]      sprod;

  assign full   = q_full;
  assign accept = push & ~q_full;
  assign sprod  = in_sample * in_sample;

  // accumulate, close the window or flush on error
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    q_push    = 1'b0;
    q_data    = {1'b1, {SUM_W{1'b0}}, {SQ_W{1'b0}}};
    if (ctl.clear) begin
      count_nxt = '0;
      sum_nxt   = '0;
      sq_nxt    = '0;
    end else if (accept && ctl.enable) begin
      if (in_read_error) begin
        q_push    = 1'b1;
        count_nxt = '0;
        sum_nxt   = '0;
        sq_nxt    = '0;
      end else begin
        sum_nxt = sum_r + SUM_W'(in_sample);
        sq_nxt  = sq_r + SQ_W'(sprod[30:0]);
        if (count_r == LAST) begin
          q_push    = 1'b1;
          q_data    = {1'b0, sum_nxt, sq_nxt};
          count_nxt = '0;
          sum_nxt   = '0;
          sq_nxt    = '0;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdlm_fifo.sv =====
// ----------------------------------------------------------------------------
// rdlm_fifo
// Short job queue between the sample front end and the dB back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rdlm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rdlm_pkg::FIFO_DEPTH
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_en,
  input  wire [WIDTH-1:0]  wr_data,
  output logic             full,
  input  wire              rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import rdlm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rp_r];

  // store a job
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      if (do_wr && !do_rd) cnt_r <= cnt_r + (AW+1)'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - (AW+1)'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdlm_back.sv =====
// ----------------------------------------------------------------------------
// rdlm_back
// dB back end: variance, Q16 log2, dBFS scaling, level mapping, peak
// tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdlm_back #(
  parameter int WINDOW_SAMPLES = rdlm_pkg::WINDOW_SAMPLES_DEF
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  rdlm_pkg::back_ctl_t                          ctl,
  input  wire                                          q_empty,
  input  wire [rdlm_pkg::entry_w(WINDOW_SAMPLES)-1:0]  q_data,
  output logic                                         q_pop,
  output logic                                         empty,
  input  wire                                          pop,
  output logic [9:0]                                   out_level,
  output logic [9:0]                                   out_peak,
  output logic signed [15:0]                           out_dbfs_q8
);
  import rdlm_pkg::*;

  localparam int NB    = $clog2(WINDOW_SAMPLES + 1);
  localparam int SUM_W = 17 + NB;
  localparam int SQ_W  = 30 + NB;
  localparam int MAG_W = 15 + NB;
  localparam int M_W   = 30 + 2 * NB;
  localparam int EW    = entry_w(WINDOW_SAMPLES);
  localparam int EXP_W = $clog2(M_W);
  localparam logic signed [23:0] LOG_OFS =
    24'(2 * log2_q16_const(longint'(WINDOW_SAMPLES)) + 30 * 65536);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MULN  = 4'd1;
  localparam logic [3:0] S_SUBM  = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_LOG   = 4'd4;
  localparam logic [3:0] S_LDIFF = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_ROUND = 4'd7;
  localparam logic [3:0] S_MAP   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic [M_W-1:0]          acc_r, acc_nxt, sqs_r, sqs_nxt, sq2_r, sq2_nxt, m_r, m_nxt;
  logic [NB-1:0]           nsh_r, nsh_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [EXP_W-1:0]        exp_r, exp_nxt;
  logic [15:0]             frac_r, frac_nxt;
  logic [31:0]             y_r, y_nxt;
  logic [3:0]              cnt_r, cnt_nxt;
  logic signed [23:0]      l_r, l_nxt;
  logic signed [43:0]      prod_r, prod_nxt;
  logic signed [15:0]      db_r, db_nxt;
  logic [27:0]             rem_r, rem_nxt, dv_r, dv_nxt;
  logic [9:0]              q_r, q_nxt, level_r, level_nxt, peak_r, peak_nxt;
  logic                    ov_r, ov_nxt;
  logic [9:0]              olev_r, olev_nxt, opeak_r, opeak_nxt;
  logic signed [15:0]      odb_r, odb_nxt;

  logic                    h_err;
  logic signed [SUM_W-1:0] h_sum, h_abs;
  logic [SQ_W-1:0]         h_sq;
  logic [63:0]             ysq;
  logic [32:0]             yt;
  logic signed [19:0]      kscale;
  logic                    pneg;
  logic [43:0]             pabs;
  logic [19:0]             rq;
  logic signed [20:0]      dsg;
  logic signed [16:0]      den, num;
  logic [9:0]              newpk;

  assign h_err  = q_data[EW-1];
  assign h_sum  = $signed(q_data[SQ_W +: SUM_W]);
  assign h_sq   = q_data[SQ_W-1:0];
  assign h_abs  = h_sum[SUM_W-1] ? -h_sum : h_sum;
  assign ysq    = y_r * y_r;
  assign yt     = ysq[63:31];
  assign kscale = $signed({1'b0, TEN_LOG10_2_Q16});
  assign pneg   = prod_r[43];
  assign pabs   = pneg ? 44'(-prod_r) : 44'(prod_r);
  assign rq     = 20'((pabs + 44'(1 << 23)) >> 24);
  assign dsg    = pneg ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
  assign den    = 17'(ctl.loud_db) - 17'(ctl.floor_db);
  assign num    = 17'(db_r) - 17'(ctl.floor_db);
  assign newpk  = (level_r > peak_r) ? level_r : peak_r;

  assign empty       = ~ov_r;
  assign out_level   = olev_r;
  assign out_peak    = opeak_r;
  assign out_dbfs_q8 = odb_r;

  // job sequencer
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    sqs_nxt   = sqs_r;
    sq2_nxt   = sq2_r;
    m_nxt     = m_r;
    nsh_nxt   = nsh_r;
    mag_nxt   = mag_r;
    exp_nxt   = exp_r;
    frac_nxt  = frac_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    l_nxt     = l_r;
    prod_nxt  = prod_r;
    db_nxt    = db_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    level_nxt = level_r;
    peak_nxt  = peak_r;
    ov_nxt    = ov_r;
    olev_nxt  = olev_r;
    opeak_nxt = opeak_r;
    odb_nxt   = odb_r;
    q_pop     = 1'b0;

    if (pop && ov_r) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (h_err) begin
            level_nxt = '0;
            db_nxt    = DB_FLOOR_Q8;
            state_nxt = S_OUT;
          end else begin
            sqs_nxt   = M_W'(h_sq);
            acc_nxt   = '0;
            nsh_nxt   = NB'(WINDOW_SAMPLES);
            mag_nxt   = h_abs[MAG_W-1:0];
            state_nxt = S_MULN;
          end
        end
      end
      // N * square_sum by shift and add, one bit of N a cycle
      S_MULN: begin
        sq2_nxt = M_W'(mag_r) * M_W'(mag_r);
        if (nsh_r[0]) acc_nxt = acc_r + sqs_r;
        sqs_nxt = sqs_r << 1;
        nsh_nxt = nsh_r >> 1;
        if ((nsh_r >> 1) == '0) state_nxt = S_SUBM;
      end
      S_SUBM: begin
        m_nxt     = acc_r - sq2_r;
        exp_nxt   = EXP_W'(M_W - 1);
        state_nxt = S_NORM;
      end
      // normalize one bit a cycle to find the msb
      S_NORM: begin
        if (m_r == '0) begin
          db_nxt    = DB_FLOOR_Q8;
          state_nxt = S_MAP;
        end else if (m_r[M_W-1]) begin
          y_nxt     = m_r[M_W-1 -: 32];
          frac_nxt  = '0;
          cnt_nxt   = 4'd15;
          state_nxt = S_LOG;
        end else begin
          m_nxt   = m_r << 1;
          exp_nxt = exp_r - EXP_W'(1);
        end
      end
      // one fraction bit per squaring of the mantissa
      S_LOG: begin
        if (yt[32]) begin
          frac_nxt[cnt_r] = 1'b1;
          y_nxt           = yt[32:1];
        end else begin
          y_nxt = yt[31:0];
        end
        if (cnt_r == 4'd0) state_nxt = S_LDIFF;
        else cnt_nxt = cnt_r - 4'd1;
      end
      S_LDIFF: begin
        l_nxt     = $signed(24'({exp_r, frac_r})) - LOG_OFS;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        prod_nxt  = l_r * kscale;
        state_nxt = S_ROUND;
      end
      // round half away from zero, clamp to [-120 dB, 0]
      S_ROUND: begin
        if (dsg < 21'(DB_FLOOR_Q8)) db_nxt = DB_FLOOR_Q8;
        else if (dsg > 21'sd0) db_nxt = '0;
        else db_nxt = 16'(dsg);
        state_nxt = S_MAP;
      end
      S_MAP: begin
        state_nxt = S_OUT;
        if (den <= 17'sd0) begin
          level_nxt = (db_r >= ctl.loud_db) ? LEVEL_MAX : '0;
        end else if (num <= 17'sd0) begin
          level_nxt = '0;
        end else if (num >= den) begin
          level_nxt = LEVEL_MAX;
        end else begin
          rem_nxt   = 28'(num[15:0]) * 28'd2000 + 28'(den[15:0]);
          dv_nxt    = 28'({den[15:0], 10'b0});
          q_nxt     = '0;
          cnt_nxt   = 4'd9;
          state_nxt = S_DIV;
        end
      end
      // restoring divide, one quotient bit a cycle
      S_DIV: begin
        if (rem_r >= dv_r) begin
          rem_nxt        = rem_r - dv_r;
          q_nxt[cnt_r]   = 1'b1;
        end
        dv_nxt = dv_r >> 1;
        if (cnt_r == 4'd0) begin
          level_nxt = q_nxt;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      // hold until the result register is free
      S_OUT: begin
        if (!ov_r || pop) begin
          peak_nxt  = newpk;
          ov_nxt    = 1'b1;
          olev_nxt  = level_r;
          opeak_nxt = newpk;
          odb_nxt   = db_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (ctl.clear_peak) peak_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      peak_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    sqs_r   <= sqs_nxt;
    sq2_r   <= sq2_nxt;
    m_r     <= m_nxt;
    nsh_r   <= nsh_nxt;
    mag_r   <= mag_nxt;
    exp_r   <= exp_nxt;
    frac_r  <= frac_nxt;
    y_r     <= y_nxt;
    cnt_r   <= cnt_nxt;
    l_r     <= l_nxt;
    prod_r  <= prod_nxt;
    db_r    <= db_nxt;
    rem_r   <= rem_nxt;
    dv_r    <= dv_nxt;
    q_r     <= q_nxt;
    level_r <= level_nxt;
    olev_r  <= olev_nxt;
    opeak_r <= opeak_nxt;
    odb_r   <= odb_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rdlm_checker.sv =====
// ----------------------------------------------------------------------------
// rdlm_checker
// Port-level checks on the level meter's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rms_dbfs_level_meter_unit_macros.svh"

module rdlm_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               empty,
  input wire [9:0]         out_level,
  input wire [9:0]         out_peak,
  input wire signed [15:0] out_dbfs_q8
);
  import rdlm_pkg::*;

  `RDLM_ASSERT_ALWAYS(a_level_range, clk, rst_n, empty || out_level <= LEVEL_MAX, "level above full scale")
  `RDLM_ASSERT_ALWAYS(a_peak_covers, clk, rst_n, empty || out_peak >= out_level, "peak below level")
  `RDLM_ASSERT_ALWAYS(a_db_range, clk, rst_n, empty || (out_dbfs_q8 <= 16'sd0 && out_dbfs_q8 >= DB_FLOOR_Q8), "dBFS out of range")
  `RDLM_ASSERT_NEXT(a_reset_empty, clk, !rst_n, empty, "result pending after reset")

endmodule

bind rms_dbfs_level_meter_unit rdlm_checker u_rdlm_checker (.*);

`default_nettype wire
